// ===== hw/rtl/nsr_pkg.sv =====
// Shared types, constants and character helpers for the sentence receiver.
`default_nettype none
package nsr_pkg;

   localparam int unsigned LINE_BUFFER_BYTES_DEFAULT = 200;
   localparam int unsigned PREFIX_COUNT = 6;
   localparam int unsigned MIN_LINE_BYTES = 5;
   localparam int unsigned ACK_FIELD_POS = 9;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Prefix text, first character in the top byte, padded with spaces
   localparam logic [119:0] PREFIX_TEXT [PREFIX_COUNT] = '{
      "$PMGNCSM,      ",
      "$PMGNWPT,      ",
      "$PMGNTRK,      ",
      "$PMGNVER,      ",
      "$PMGNCMD,UNABLE",
      "$PMGNCMD,END   "
   };
   localparam int unsigned PREFIX_LEN [PREFIX_COUNT] = '{9, 7, 7, 9, 15, 12};

   typedef enum logic [2:0] {
      CLASS_OTHER  = 3'd0,
      CLASS_CSM    = 3'd1,
      CLASS_WPT    = 3'd2,
      CLASS_TRK    = 3'd3,
      CLASS_VER    = 3'd4,
      CLASS_UNABLE = 3'd5,
      CLASS_END    = 3'd6
   } nsr_class_type;

   // Snapshot of a closed line, handed from the framer to the evaluator
   typedef struct packed {
      logic [PREFIX_COUNT-1:0] match;
      logic [PREFIX_COUNT-1:0] len_ok;
      logic [7:0]              csum;
      logic [7:0]              digit_hi;
      logic [7:0]              digit_lo;
      logic [7:0]              ack_value;
   } nsr_close_type;

   // Returns {valid, value} for an ASCII hex digit
   function automatic logic [4:0] hex_digit(logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if ((c inside {[8'h41:8'h46]}) || (c inside {[8'h61:8'h66]})) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   endfunction

   function automatic logic [7:0] prefix_char(logic [2:0] t, logic [3:0] p);
      logic [6:0] lsb;
      lsb = {3'b000, 4'd14 - p} << 3;
      return PREFIX_TEXT[t][lsb +: 8];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nsr_line_framer.sv =====
// Per-byte line state: position, XOR, prefix matches, ack field, line close record.
`default_nettype none
module nsr_line_framer #(
   parameter int unsigned LINE_BUFFER_BYTES = nsr_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_valid,
   input  wire logic [7:0]            byte_data,
   input  wire logic                  take,
   output logic                       byte_ready,
   output logic                       close_valid,
   output nsr_pkg::nsr_close_type     close_rec
);
   import nsr_pkg::*;

   localparam int unsigned POS_W = $clog2(LINE_BUFFER_BYTES);

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [7:0]              xor_ff, xor_in;
   logic [15:0]             last_ff, last_in;
   logic [PREFIX_COUNT-1:0] match_ff, match_in, match_nx;
   logic [8:0]              accum_ff, accum_in, accum_nx;
   logic [7:0]              csum_ff, csum_in, csum_nx;
   logic [15:0]             digit_ff, digit_in, digit_nx;
   logic                    close_valid_ff, close_valid_in;
   nsr_close_type           close_ff, close_in;

   logic [POS_W:0]          count;
   logic [3:0]              pos_lo;
   logic [4:0]              hex_b;
   logic                    accept, closing;
   logic [PREFIX_COUNT-1:0] len_ok;

   assign byte_ready  = !close_valid_ff || take;
   assign accept      = byte_valid && byte_ready;
   assign close_valid = close_valid_ff;
   assign close_rec   = close_ff;

   assign count   = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};
   assign pos_lo  = (32'(pos_ff) < 32'd15) ? pos_ff[3:0] : 4'd0;
   assign hex_b   = hex_digit(byte_data);
   assign closing = (byte_data == CHAR_LF) ||
                    (count >= (POS_W+1)'(LINE_BUFFER_BYTES - 1));

   always_comb begin
      match_nx = match_ff;
      for (int t = 0; t < PREFIX_COUNT; t++) begin
         if ((32'(pos_ff) < PREFIX_LEN[t]) && (byte_data != prefix_char(3'(t), pos_lo))) begin
            match_nx[t] = 1'b0;
         end
         len_ok[t] = (32'(count) >= PREFIX_LEN[t]);
      end
   end

   // Hex digits of the ack field start at a fixed column and stop at the first non-hex byte
   always_comb begin
      accum_nx = accum_ff;
      if (pos_ff == POS_W'(ACK_FIELD_POS)) begin
         accum_nx = hex_b[4] ? {1'b1, 4'd0, hex_b[3:0]} : 9'd0;
      end else if ((32'(pos_ff) > ACK_FIELD_POS) && accum_ff[8]) begin
         accum_nx = hex_b[4] ? {1'b1, accum_ff[3:0], hex_b[3:0]} : {1'b0, accum_ff[7:0]};
      end
   end

   // Snapshot checksum and digit pair at every printable byte
   always_comb begin
      csum_nx  = csum_ff;
      digit_nx = digit_ff;
      if (byte_data inside {[8'h20:8'h7E]}) begin
         csum_nx = xor_ff;
         if (32'(pos_ff) >= 32'd2) begin
            csum_nx = csum_nx ^ last_ff[7:0];
         end
         if (32'(pos_ff) >= 32'd3) begin
            csum_nx = csum_nx ^ last_ff[15:8];
         end
         digit_nx = {last_ff[7:0], byte_data};
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      xor_in   = xor_ff;
      last_in  = last_ff;
      match_in = match_ff;
      accum_in = accum_ff;
      csum_in  = csum_ff;
      digit_in = digit_ff;
      if (accept) begin
         if (closing) begin
            pos_in   = '0;
            xor_in   = '0;
            last_in  = '0;
            match_in = '1;
            accum_in = '0;
            csum_in  = '0;
            digit_in = '0;
         end else begin
            pos_in   = count[POS_W-1:0];
            xor_in   = (pos_ff != '0) ? (xor_ff ^ byte_data) : xor_ff;
            last_in  = {last_ff[7:0], byte_data};
            match_in = match_nx;
            accum_in = accum_nx;
            csum_in  = csum_nx;
            digit_in = digit_nx;
         end
      end
   end

   always_comb begin
      close_valid_in = close_valid_ff && !take;
      close_in       = close_ff;
      if (accept && closing && (count >= (POS_W+1)'(MIN_LINE_BYTES))) begin
         close_valid_in     = 1'b1;
         close_in.match     = match_nx;
         close_in.len_ok    = len_ok;
         close_in.csum      = csum_nx;
         close_in.digit_hi  = digit_nx[15:8];
         close_in.digit_lo  = digit_nx[7:0];
         close_in.ack_value = accum_nx[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         xor_ff         <= '0;
         last_ff        <= '0;
         match_ff       <= '1;
         accum_ff       <= '0;
         csum_ff        <= '0;
         digit_ff       <= '0;
         close_valid_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         xor_ff         <= xor_in;
         last_ff        <= last_in;
         match_ff       <= match_in;
         accum_ff       <= accum_in;
         csum_ff        <= csum_in;
         digit_ff       <= digit_in;
         close_valid_ff <= close_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      close_ff <= close_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/nsr_sentence_eval.sv =====
// Closed-line evaluation: checksum parse, class, ack decision and the result register.
`default_nettype none
module nsr_sentence_eval (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  file_mode,
   input  wire logic                  close_valid,
   input  wire nsr_pkg::nsr_close_type close_rec,
   output logic                       take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [2:0]                 rsp_msg_class,
   output logic                       rsp_checksum_ok,
   output logic [7:0]                 rsp_rx_checksum,
   output logic                       rsp_send_ack,
   output logic [7:0]                 rsp_peer_checksum,
   output logic                       rsp_transfer_done,
   output logic                       rsp_link_error,
   output logic                       rsp_bad_link
);
   import nsr_pkg::*;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    peer_ff, peer_in;
   logic          version_ff, version_in;
   nsr_class_type cls_ff, cls_in;
   logic          ok_ff, ack_ff, done_ff, lerr_ff, bad_ff;
   logic [7:0]    rx_ff;

   logic [4:0]    dh, dl;
   logic [7:0]    rx;
   nsr_class_type cls;
   logic          ok, bad, advance;

   assign take    = !rsp_valid_ff || rsp_ready;
   assign advance = close_valid && take;

   assign dh = hex_digit(close_rec.digit_hi);
   assign dl = hex_digit(close_rec.digit_lo);

   always_comb begin
      if (dh[4]) begin
         rx = dl[4] ? {dh[3:0], dl[3:0]} : {4'd0, dh[3:0]};
      end else if (is_space(close_rec.digit_hi) && dl[4]) begin
         rx = {4'd0, dl[3:0]};
      end else begin
         rx = 8'd0;
      end
   end

   // First matching prefix wins
   always_comb begin
      cls = CLASS_OTHER;
      for (int t = PREFIX_COUNT - 1; t >= 0; t--) begin
         if (close_rec.match[t] && close_rec.len_ok[t]) begin
            cls = nsr_class_type'(3'(t + 1));
         end
      end
   end

   assign ok  = (rx == close_rec.csum);
   assign bad = !ok && !(version_ff || file_mode);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      peer_in      = peer_ff;
      version_in   = version_ff;
      cls_in       = cls_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         cls_in       = cls;
         if (!bad && (cls == CLASS_CSM)) begin
            peer_in = close_rec.ack_value;
         end
         if (!bad && (cls == CLASS_VER)) begin
            version_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         peer_ff      <= '0;
         version_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         peer_ff      <= peer_in;
         version_ff   <= version_in;
      end
   end

   // Hold the result while the transfer stalls
   always_ff @(posedge clock) begin
      cls_ff <= cls_in;
      if (advance) begin
         ok_ff   <= ok;
         rx_ff   <= rx;
         bad_ff  <= bad;
         ack_ff  <= !bad && !file_mode &&
                    ((cls == CLASS_OTHER) || (cls == CLASS_WPT) || (cls == CLASS_TRK));
         done_ff <= !bad && ((cls == CLASS_UNABLE) || (cls == CLASS_END));
         lerr_ff <= !bad && (cls == CLASS_UNABLE);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_msg_class     = cls_ff;
   assign rsp_checksum_ok   = ok_ff;
   assign rsp_rx_checksum   = rx_ff;
   assign rsp_send_ack      = ack_ff;
   assign rsp_peer_checksum = peer_ff;
   assign rsp_transfer_done = done_ff;
   assign rsp_link_error    = lerr_ff;
   assign rsp_bad_link      = bad_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/nmea_sentence_receiver_ack.sv =====
// A line's result passes from its closing byte transfer through the framer's close register, then the result register.
// Throughput: one byte per cycle while req_ready is high; the line state updates in a single pass per byte.
// A closed line waits in the framer's close register while the result register stalls.
// Reset (synchronous): line state, peer checksum, version flag and file mode clear;
// no clearing pass, bytes are taken as soon as reset is released.
`default_nettype none
module nmea_sentence_receiver_ack #(
   parameter int unsigned LINE_BUFFER_BYTES = nsr_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_file_mode,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_msg_class,
   output logic            rsp_checksum_ok,
   output logic [7:0]      rsp_rx_checksum,
   output logic            rsp_send_ack,
   output logic [7:0]      rsp_peer_checksum,
   output logic            rsp_transfer_done,
   output logic            rsp_link_error,
   output logic            rsp_bad_link
);
   import nsr_pkg::*;

   logic          file_mode_ff, file_mode_in;
   logic          take, close_valid;
   nsr_close_type close_rec;

   assign csr_ready    = 1'b1;
   assign file_mode_in = (csr_valid && csr_ready) ? csr_file_mode : file_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_mode_ff <= 1'b0;
      end else begin
         file_mode_ff <= file_mode_in;
      end
   end

   nsr_line_framer #(
      .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid),
      .byte_data  (req_rx_byte),
      .take       (take),
      .byte_ready (req_ready),
      .close_valid(close_valid),
      .close_rec  (close_rec)
   );

   nsr_sentence_eval u_eval (
      .clock            (clock),
      .reset            (reset),
      .file_mode        (file_mode_ff),
      .close_valid      (close_valid),
      .close_rec        (close_rec),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_msg_class    (rsp_msg_class),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_rx_checksum  (rsp_rx_checksum),
      .rsp_send_ack     (rsp_send_ack),
      .rsp_peer_checksum(rsp_peer_checksum),
      .rsp_transfer_done(rsp_transfer_done),
      .rsp_link_error   (rsp_link_error),
      .rsp_bad_link     (rsp_bad_link)
   );

endmodule
`default_nettype wire
